// ===== hdl/assert_macros.svh =====
// Assertion macros used by the converter's controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising edge outside reset.
`define B2DA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at each rising edge outside reset.
`define B2DA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/b2da_pkg.sv =====
// Shared types, constants and helpers of the binary to decimal ASCII converter.
package b2da_pkg;

   localparam int IN_BITS    = 16;
   localparam int DIGIT_BITS = 4;
   localparam int ASCII_BITS = 6;
   localparam logic [ASCII_BITS-1:0] ASCII_ZERO = 6'd48;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;    // capture a new value, clear the BCD register
      logic shift;   // one double-dabble step
      logic step;    // drop the leading digit, advance the digit count
      logic put;     // write the leading digit to the output register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic conv_done;    // last bit is being shifted in
      logic emit_now;     // leading digit is part of the text
      logic final_digit;  // leading digit is the units digit
   } sts_type;

   // Number of decimal digits needed for the largest value of the given width.
   function automatic int dec_digits(input int bits);
      longint max_v;
      longint p;
      int     n;
      max_v = (longint'(1) << bits) - 1;
      p     = 10;
      n     = 1;
      while (p <= max_v) begin
         p = p * 10;
         n = n + 1;
      end
      return n;
   endfunction

endpackage

// ===== hdl/binary_to_decimal_ascii.sv =====
// Top level of the binary to decimal ASCII converter.
//
// Accepts one unsigned number per req_ word (only the low VALUE_BITS bits, at most 16,
// take part) and returns its decimal text as a run of rsp_ words, one ASCII digit each,
// most significant first, with leading zeros dropped; zero gives a single '0'.
// rsp_last marks the units digit. Conversion is shift-and-add-3 (double dabble), one
// input bit per cycle: an item is captured, converted with one shift step per live
// input bit, then unloaded with one step per decimal digit position of the widest
// value (5 at 16 bits), where a real digit waits while the consumer holds rsp_ready low.
// The conversion loop handles one item at a time; the output word register lets the
// next item be taken while the units digit still waits.
module binary_to_decimal_ascii #(
   parameter int VALUE_BITS = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [b2da_pkg::IN_BITS-1:0]         req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [b2da_pkg::ASCII_BITS-1:0]      rsp_ascii_digit,
   output logic                                 rsp_last
);

   // Bits above the input field never take part.
   localparam int VAL_BITS = (VALUE_BITS < b2da_pkg::IN_BITS) ? VALUE_BITS
                                                              : b2da_pkg::IN_BITS;

   b2da_pkg::cmd_type cmd;
   b2da_pkg::sts_type sts;

   // Sequencer: idle, convert, then unload digits into the output register.
   b2da_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // Binary and BCD shift registers, digit count and output word payload.
   b2da_datapath #(
      .VAL_BITS (VAL_BITS)
   ) u_datapath (
      .clock           (clock),
      .req_value       (req_value),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_ascii_digit (rsp_ascii_digit),
      .rsp_last        (rsp_last)
   );

endmodule

// ===== hdl/b2da_datapath.sv =====
// Datapath: shift-and-add-3 converter, digit unloader and output word register.
module b2da_datapath #(
   parameter int VAL_BITS = 16
) (
   input  logic                                 clock,
   input  logic [b2da_pkg::IN_BITS-1:0]         req_value,
   input  b2da_pkg::cmd_type                    cmd,
   output b2da_pkg::sts_type                    sts,
   output logic [b2da_pkg::ASCII_BITS-1:0]      rsp_ascii_digit,
   output logic                                 rsp_last
);

   localparam int ND    = b2da_pkg::dec_digits(VAL_BITS);
   localparam int DW    = b2da_pkg::DIGIT_BITS;
   localparam int BCD_W = ND * DW;
   localparam int BCW   = $clog2(VAL_BITS);
   localparam int DCW   = $clog2(ND);

   logic [VAL_BITS-1:0] bin_ff, bin_in;
   logic [BCD_W-1:0]    bcd_ff, bcd_in, bcd_adj;
   logic [BCW-1:0]      bit_cnt_ff, bit_cnt_in;
   logic [DCW-1:0]      dig_cnt_ff, dig_cnt_in;
   logic                started_ff, started_in;
   logic [DW-1:0]       digit_ff, digit_in;
   logic                last_ff, last_in;
   logic [DW-1:0]       top_digit;

   assign top_digit = bcd_ff[BCD_W-1 -: DW];

   // Add 3 to every digit of 5 or more before the shift.
   always_comb begin
      for (int i = 0; i < ND; i++) begin
         if (bcd_ff[i*DW +: DW] >= 4'd5) begin
            bcd_adj[i*DW +: DW] = bcd_ff[i*DW +: DW] + 4'd3;
         end else begin
            bcd_adj[i*DW +: DW] = bcd_ff[i*DW +: DW];
         end
      end
   end

   always_comb begin
      bin_in     = bin_ff;
      bcd_in     = bcd_ff;
      bit_cnt_in = bit_cnt_ff;
      dig_cnt_in = dig_cnt_ff;
      started_in = started_ff;
      digit_in   = digit_ff;
      last_in    = last_ff;
      if (cmd.load) begin
         bin_in     = req_value[VAL_BITS-1:0];
         bcd_in     = '0;
         bit_cnt_in = BCW'(VAL_BITS - 1);
         dig_cnt_in = DCW'(ND - 1);
         started_in = 1'b0;
      end else if (cmd.shift) begin
         bcd_in     = {bcd_adj[BCD_W-2:0], bin_ff[VAL_BITS-1]};
         bin_in     = {bin_ff[VAL_BITS-2:0], 1'b0};
         bit_cnt_in = bit_cnt_ff - 1'b1;
      end else if (cmd.step) begin
         bcd_in     = {bcd_ff[BCD_W-DW-1:0], {DW{1'b0}}};
         dig_cnt_in = dig_cnt_ff - 1'b1;
         started_in = started_ff | (top_digit != '0);
      end
      if (cmd.put) begin
         digit_in = top_digit;
         last_in  = sts.final_digit;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff     <= bin_in;
      bcd_ff     <= bcd_in;
      bit_cnt_ff <= bit_cnt_in;
      dig_cnt_ff <= dig_cnt_in;
      started_ff <= started_in;
      digit_ff   <= digit_in;
      last_ff    <= last_in;
   end

   assign sts.conv_done   = (bit_cnt_ff == '0);
   assign sts.final_digit = (dig_cnt_ff == '0);
   assign sts.emit_now    = started_ff | (top_digit != '0) | (dig_cnt_ff == '0);

   assign rsp_ascii_digit = b2da_pkg::ASCII_ZERO + {2'b00, digit_ff};
   assign rsp_last        = last_ff;

endmodule

// ===== hdl/b2da_ctrl.sv =====
// Controller: sequences capture, conversion and digit output; owns the output valid.
`include "assert_macros.svh"

module b2da_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  b2da_pkg::sts_type sts,
   output b2da_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;
   logic      adv;

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // Skip a leading zero at once; a real digit waits for a free output register.
   assign adv       = (state_ff == ST_EMIT) && (!sts.emit_now || out_free);

   always_comb begin
      cmd.load  = req_valid && req_ready;
      cmd.shift = (state_ff == ST_CONV);
      cmd.step  = adv;
      cmd.put   = adv && sts.emit_now;
   end

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.put) begin
         rsp_valid_in = 1'b1;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            if (sts.conv_done) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (adv && sts.final_digit) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `B2DA_ASSERT_IMP(a_no_overwrite, clock, reset, cmd.put, (state_ff == ST_EMIT) && out_free, "b2da: output word overwritten")
   `B2DA_ASSERT_NXT(a_conv_to_emit, clock, reset, (state_ff == ST_CONV) && sts.conv_done, state_ff == ST_EMIT, "b2da: conversion end missed")
   `B2DA_ASSERT_IMP(a_units_emitted, clock, reset, (state_ff == ST_EMIT) && sts.final_digit, sts.emit_now, "b2da: units digit skipped")
   `B2DA_ASSERT_IMP(a_one_cmd, clock, reset, 1'b1, $onehot0({cmd.load, cmd.shift, cmd.step}), "b2da: conflicting commands")

endmodule

// ===== tb/binary_to_decimal_ascii_test.sv =====
// Self-checking testbench for the binary to decimal ASCII converter.
`timescale 1ns / 100ps

module binary_to_decimal_ascii_test;

   localparam int IN_BITS       = b2da_pkg::IN_BITS;
   localparam int ASCII_BITS    = b2da_pkg::ASCII_BITS;
   localparam int VALUE_BITS    = 16;
   // Only the low VALUE_BITS bits of a number take part, never more than the port width.
   localparam int LIVE_BITS     = (VALUE_BITS < IN_BITS) ? VALUE_BITS : IN_BITS;
   localparam logic [IN_BITS-1:0] VALUE_MASK = {IN_BITS{1'b1}} >> (IN_BITS - LIVE_BITS);
   localparam logic [ASCII_BITS-1:0] CHAR_ZERO = 6'd48;
   localparam int MAX_IDLE      = 18;
   // Give the tail plenty of room after the last item.
   localparam int SETTLE_CYCLES = 40;
   // Far above the slowest correct run of about 150 items with the longest gaps and stalls.
   localparam int CLOCK_LIMIT   = 200000;

   // One result word: a digit character and its end-of-run flag.
   typedef struct packed {
      logic [ASCII_BITS-1:0] ascii;
      logic                  last;
   } digit_word_type;

   logic                  clock     = 1'b0;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [IN_BITS-1:0]    req_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [ASCII_BITS-1:0] rsp_ascii_digit;
   logic                  rsp_last;

   digit_word_type pending_digits[$];   // characters still owed by the block, oldest first
   int          error_count = 0;
   int          cycle_count = 0;
   int          digits_taken = 0;    // result words accepted so far
   int          digits_seen  = 0;    // receiver's copy of digits_taken
   int          rsp_hold     = 0;    // cycles the receiver still holds rsp_ready low
   bit          no_idle      = 1'b0; // suppress gaps and stalls on both sides

   binary_to_decimal_ascii #(
      .VALUE_BITS(VALUE_BITS)
   ) DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_ascii_digit (rsp_ascii_digit),
      .rsp_last        (rsp_last)
   );

   always #5 clock = ~clock;

   // Hard stop in case the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CLOCK_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      $display("[%0t] MISMATCH: %s", $realtime, msg);
      error_count++;
   endtask

   // Queue the decimal text of one number: most significant digit first,
   // no leading zeros, a lone '0' for zero, last flag on the units digit.
   function automatic void predict_digits(input logic [IN_BITS-1:0] value);
      logic [IN_BITS-1:0] rest;
      logic [3:0]         units_first[10];
      int                 count;
      digit_word_type     word;
      rest  = value & VALUE_MASK;
      count = 0;
      do begin
         units_first[count] = 4'(rest % 10);
         rest = IN_BITS'(rest / 10);
         count++;
      end while (rest != 0 && count < 10);
      for (int k = 0; k < count; k++) begin
         word.ascii = ASCII_BITS'(units_first[count-1-k]) + CHAR_ZERO;
         word.last  = (k == count - 1);
         pending_digits.push_back(word);
      end
   endfunction

   // Draw a number whose decimal length is spread evenly over 1..5 digits,
   // with some fully random words mixed in.
   function automatic logic [IN_BITS-1:0] random_value();
      int unsigned length;
      length = $urandom_range(0, 5);
      case (length)
         1: return IN_BITS'($urandom_range(0, 9));
         2: return IN_BITS'($urandom_range(10, 99));
         3: return IN_BITS'($urandom_range(100, 999));
         4: return IN_BITS'($urandom_range(1000, 9999));
         5: return IN_BITS'($urandom_range(10000, 65535));
         default: return IN_BITS'($urandom);
      endcase
   endfunction

   // Receiver: after every accepted word, draw a fresh stall and hold
   // rsp_ready low for that many cycles. Drive at the falling edge.
   always @(negedge clock) begin
      if (digits_seen != digits_taken) begin
         digits_seen = digits_taken;
         rsp_hold    = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      end
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Checker: compare each accepted word with the oldest expected character.
   always @(posedge clock) begin
      digit_word_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         digits_taken++;
         if (pending_digits.size() == 0) begin
            report_mismatch($sformatf("unexpected word: digit 0x%0h last %0b",
                                      rsp_ascii_digit, rsp_last));
         end else begin
            want = pending_digits.pop_front();
            if (rsp_ascii_digit !== want.ascii)
               report_mismatch($sformatf("digit 0x%0h, expected 0x%0h",
                                         rsp_ascii_digit, want.ascii));
            if (rsp_last !== want.last)
               report_mismatch($sformatf("last %0b, expected %0b (digit 0x%0h)",
                                         rsp_last, want.last, want.ascii));
         end
      end
   end

   // Send one number. Entered at a falling edge; leaves at the falling edge
   // after the word is taken, with req_valid still high so that a next word
   // with no gap follows without a low cycle.
   task automatic send_value(input logic [IN_BITS-1:0] value);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
         // Drop valid and wiggle the idle bus so stale data is never mistaken for a word.
         req_valid <= 1'b0;
         req_value <= IN_BITS'($urandom);
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_value <= value;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_digits(value);
      @(negedge clock);
   endtask

   // Hold the sender until every expected character has come back,
   // then let the block sit idle a little longer.
   task automatic wait_for_digits(input int settle);
      req_valid <= 1'b0;
      while (pending_digits.size() != 0) @(negedge clock);
      repeat (settle) @(negedge clock);
   endtask

   // Digit-count boundaries, zero, the full range and alternating bit patterns.
   task automatic test_corner_values();
      logic [IN_BITS-1:0] corners[$] = '{
         16'd0, 16'd1, 16'd9, 16'd10, 16'd99, 16'd100, 16'd999, 16'd1000,
         16'd9999, 16'd10000, 16'd65535, 16'd65534, 16'd32768, 16'h5555,
         16'hAAAA, 16'd12345, 16'd54321, 16'd60000, 16'h00FF, 16'hFF00 };
      foreach (corners[i]) send_value(corners[i]);
      wait_for_digits(2);
   endtask

   // Full rate on both sides: no gaps, no stalls.
   task automatic test_back_to_back();
      no_idle = 1'b1;
      repeat (30) send_value(random_value());
      wait_for_digits(2);
      no_idle = 1'b0;
   endtask

   // Random gaps on the sender and random stalls on the receiver.
   task automatic test_random_pacing();
      repeat (60) send_value(random_value());
      wait_for_digits(2);
   endtask

   // Short bursts, each followed by a full drain so the block restarts from idle.
   task automatic test_drain_between_bursts();
      repeat (12) begin
         repeat ($urandom_range(1, 3)) send_value(random_value());
         wait_for_digits(2);
      end
   endtask

   initial begin
      // Hold reset, then release it at a falling edge.
      repeat (4) @(negedge clock);
      reset <= 1'b0;

      test_corner_values();
      test_back_to_back();
      test_random_pacing();
      test_drain_between_bursts();

      // Wait out the tail so that any stray word is caught.
      wait_for_digits(SETTLE_CYCLES);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
